/* hdl/midi_event_queue_with_drop_flags_unit_defines.svh */
// Assertion macros shared by the MIDI event queue modules.
`ifndef MIDI_EVENT_QUEUE_WITH_DROP_FLAGS_UNIT_DEFINES_SVH
`define MIDI_EVENT_QUEUE_WITH_DROP_FLAGS_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define MEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MEQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define MEQ_ASSERT(label, prop, msg)
`define MEQ_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* hdl/meq_pkg.sv */
// Types, sizes and codes of the MIDI event queue.
package meq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  localparam int OPQ_DEPTH   = 4;
  localparam int OPQ_IDX_W   = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);

  localparam logic [63:0] MIX_C0 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_RECOVER = 2'd2;

  localparam logic [2:0] KIND_NOTE_ON   = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF  = 3'd1;
  localparam logic [2:0] KIND_CONTROL   = 3'd2;
  localparam logic [2:0] KIND_PRESSURE  = 3'd3;

  localparam logic [3:0] MIDI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON   = 4'h9;
  localparam logic [3:0] MIDI_CONTROL   = 4'hB;
  localparam logic [3:0] MIDI_PRESSURE  = 4'hD;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic        source;
    logic [63:0] timestamp_micros;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  kind;
    logic [4:0]  channel;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
    logic        event_source;
    logic [63:0] event_sequence;
    logic [63:0] event_time;
    logic [31:0] lifecycle_seed;
    logic [31:0] dropped_count;
  } result_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        valid;
    logic [2:0]  kind;
    logic [4:0]  channel;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
    logic        source;
    logic [63:0] seq_num;
    logic [63:0] timestamp;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } opq_status_t;

endpackage

/* hdl/meq_front.sv */
// Front end: takes commands, decodes MIDI messages and numbers enqueues.
module meq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  meq_pkg::cmd_t       cmd_i,
  input  meq_pkg::opq_status_t opq_status_i,
  output logic                busy_o,
  output logic                push_o,
  output meq_pkg::op_t        op_o
);
  import meq_pkg::*;

  logic [63:0] seq_q, seq_d;
  logic [3:0]  msg_type;

  assign busy_o   = opq_status_i.full;
  assign push_o   = start_i && !opq_status_i.full;
  assign msg_type = cmd_i.status_byte[7:4];

  always_comb begin
    op_o              = '0;
    op_o.action       = cmd_i.action;
    op_o.valid        = 1'b1;
    op_o.kind         = KIND_NOTE_ON;
    op_o.channel      = {1'b0, cmd_i.status_byte[3:0]} + 5'd1;
    op_o.first_value  = cmd_i.first_data;
    op_o.second_value = cmd_i.second_data;
    op_o.source       = cmd_i.source;
    op_o.seq_num      = seq_q;
    op_o.timestamp    = cmd_i.timestamp_micros;
    if (msg_type == MIDI_NOTE_ON && cmd_i.second_data != 7'd0) begin
      op_o.kind = KIND_NOTE_ON;
    end else if (msg_type == MIDI_NOTE_OFF || msg_type == MIDI_NOTE_ON) begin
      op_o.kind = KIND_NOTE_OFF;
    end else if (msg_type == MIDI_CONTROL) begin
      op_o.kind = KIND_CONTROL;
    end else if (msg_type == MIDI_PRESSURE) begin
      op_o.kind         = KIND_PRESSURE;
      op_o.second_value = '0;
    end else begin
      op_o.valid = 1'b0;
    end
  end

  always_comb begin
    seq_d = seq_q;
    if (push_o && cmd_i.action == ACT_ENQUEUE) begin
      seq_d = seq_q + 64'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else begin
      seq_q <= seq_d;
    end
  end

endmodule

/* hdl/meq_opq.sv */
// Short operation queue between the front end and the back end.
`include "midi_event_queue_with_drop_flags_unit_defines.svh"
module meq_opq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  meq_pkg::op_t         op_i,
  input  logic                 pop_i,
  output meq_pkg::op_t         op_o,
  output meq_pkg::opq_status_t status_o
);
  import meq_pkg::*;

  localparam logic [OPQ_IDX_W-1:0] IDX_LAST = OPQ_IDX_W'(OPQ_DEPTH - 1);
  localparam logic [OPQ_CNT_W-1:0] CNT_FULL = OPQ_CNT_W'(OPQ_DEPTH);

  op_t                  entry_q [OPQ_DEPTH];
  logic [OPQ_IDX_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [OPQ_CNT_W-1:0] count_q, count_d;

  assign op_o           = entry_q[rd_q];
  assign status_o.full  = (count_q == CNT_FULL);
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == IDX_LAST) ? '0 : wr_q + OPQ_IDX_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == IDX_LAST) ? '0 : rd_q + OPQ_IDX_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + OPQ_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - OPQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= op_i;
    end
  end

  `MEQ_ASSERT(a_opq_no_overflow, push_i |-> (count_q < CNT_FULL), "operation queue overflow")
  `MEQ_ASSERT(a_opq_no_underflow, pop_i |-> (count_q != '0), "operation queue underflow")

endmodule

/* hdl/meq_back.sv */
// Back end: event ring, seed mixing, drop counter and recovery flags.
`include "midi_event_queue_with_drop_flags_unit_defines.svh"
module meq_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  meq_pkg::opq_status_t opq_status_i,
  input  meq_pkg::op_t         op_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  output meq_pkg::result_t     res_o
);
  import meq_pkg::*;

  localparam int OCC_W = PTR_W + 1;
  localparam logic [OCC_W-1:0] SPAN     = OCC_W'(2 * QUEUE_DEPTH);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * QUEUE_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_MIX    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;

  localparam logic [1:0] STEP_LO   = 2'd0;
  localparam logic [1:0] STEP_HI_A = 2'd1;
  localparam logic [1:0] STEP_HI_C = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  channel;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
    logic        source;
    logic [63:0] seq_num;
    logic [63:0] timestamp;
    logic [31:0] seed;
  } slot_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p >= PTR_HALF) ? p - PTR_HALF : p;
    return r[IDX_W-1:0];
  endfunction

  slot_t       slot_mem [QUEUE_DEPTH];
  slot_t       rd_slot_q;
  slot_t       slot_wdata;
  logic        slot_we, slot_re;

  logic [2:0]       state_q, state_d;
  op_t              op_q, op_d;
  logic [63:0]      a_q, a_d, acc_q, acc_d;
  logic             pass_q, pass_d;
  logic [1:0]       step_q, step_d;
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [31:0]      drop_q, drop_d;
  logic [1:0]       flags_q, flags_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic [OCC_W-1:0] occ_sum, occ;
  logic             ring_full, ring_empty;
  logic [63:0]      mul_c, mul_p, mix_v, fin_v;
  logic [31:0]      mul_x, mul_y;

  assign occ_sum    = {1'b0, wr_q} + SPAN - {1'b0, rd_q};
  assign occ        = (occ_sum >= SPAN) ? occ_sum - SPAN : occ_sum;
  assign ring_full  = (occ >= OCC_FULL);
  assign ring_empty = (occ == '0);

  assign mix_v = op_q.timestamp ^ (op_q.seq_num + MIX_C0);
  assign fin_v = acc_q ^ (acc_q >> 31);
  assign mul_c = pass_q ? MIX_C2 : MIX_C1;

  always_comb begin
    case (step_q)
      STEP_LO: begin
        mul_x = a_q[31:0];
        mul_y = mul_c[31:0];
      end
      STEP_HI_A: begin
        mul_x = a_q[63:32];
        mul_y = mul_c[31:0];
      end
      default: begin
        mul_x = a_q[31:0];
        mul_y = mul_c[63:32];
      end
    endcase
  end

  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  always_comb begin
    slot_wdata              = '0;
    slot_wdata.kind         = op_q.kind;
    slot_wdata.channel      = op_q.channel;
    slot_wdata.first_value  = op_q.first_value;
    slot_wdata.second_value = op_q.second_value;
    slot_wdata.source       = op_q.source;
    slot_wdata.seq_num      = op_q.seq_num;
    slot_wdata.timestamp    = op_q.timestamp;
    slot_wdata.seed         = fin_v[31:0] ^ fin_v[63:32];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    a_d         = a_q;
    acc_d       = acc_q;
    pass_d      = pass_q;
    step_d      = step_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    drop_d      = drop_q;
    flags_d     = flags_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    pop_o       = 1'b0;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!opq_status_i.empty) begin
          pop_o   = 1'b1;
          op_d    = op_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q.action)
          ACT_ENQUEUE: begin
            if (!op_q.valid) begin
              res_valid_d = 1'b1;
              state_d     = S_IDLE;
            end else if (ring_full) begin
              if (drop_q != '1) begin
                drop_d = drop_q + 32'd1;
              end
              flags_d[op_q.source] = 1'b1;
              res_valid_d          = 1'b1;
              state_d              = S_IDLE;
            end else begin
              a_d     = mix_v ^ (mix_v >> 30);
              pass_d  = 1'b0;
              step_d  = STEP_LO;
              state_d = S_MUL;
            end
          end
          ACT_DEQUEUE: begin
            if (ring_empty) begin
              res_valid_d = 1'b1;
              state_d     = S_IDLE;
            end else begin
              slot_re = 1'b1;
              state_d = S_RDWAIT;
            end
          end
          ACT_RECOVER: begin
            res_d.ok             = flags_q[op_q.source];
            flags_d[op_q.source] = 1'b0;
            res_valid_d          = 1'b1;
            state_d              = S_IDLE;
          end
          default: begin
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        if (step_q == STEP_LO) begin
          acc_d = mul_p;
        end else begin
          acc_d = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
        end
        if (step_q == STEP_HI_C) begin
          state_d = pass_q ? S_FIN : S_MIX;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      S_MIX: begin
        a_d     = acc_q ^ (acc_q >> 27);
        pass_d  = 1'b1;
        step_d  = STEP_LO;
        state_d = S_MUL;
      end
      S_FIN: begin
        slot_we     = 1'b1;
        wr_d        = ptr_next(wr_q);
        res_d.ok    = 1'b1;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_RDWAIT: begin
        res_d.ok             = 1'b1;
        res_d.kind           = rd_slot_q.kind;
        res_d.channel        = rd_slot_q.channel;
        res_d.first_value    = rd_slot_q.first_value;
        res_d.second_value   = rd_slot_q.second_value;
        res_d.event_source   = rd_slot_q.source;
        res_d.event_sequence = rd_slot_q.seq_num;
        res_d.event_time     = rd_slot_q.timestamp;
        res_d.lifecycle_seed = rd_slot_q.seed;
        rd_d                 = ptr_next(rd_q);
        res_valid_d          = 1'b1;
        state_d              = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res_d.dropped_count = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      step_q      <= STEP_LO;
      wr_q        <= '0;
      rd_q        <= '0;
      drop_q      <= '0;
      flags_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      step_q      <= step_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      drop_q      <= drop_d;
      flags_q     <= flags_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[ptr_idx(wr_q)] <= slot_wdata;
    end
    if (slot_re) begin
      rd_slot_q <= slot_mem[ptr_idx(rd_q)];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `MEQ_ASSERT(a_occ_bound, occ <= OCC_FULL, "ring occupancy above depth")
  `MEQ_ASSERT(a_write_room, slot_we |-> (occ < OCC_FULL), "ring write while full")
  `MEQ_ASSERT(a_read_data, slot_re |-> !ring_empty, "ring read while empty")
  `MEQ_ASSERT_NEXT(a_res_single, res_valid_q, !res_valid_q, "results back to back")

endmodule

/* hdl/midi_event_queue_with_drop_flags_unit.sv */
// Top level of the MIDI event queue with drop counting and recovery flags.
// A command transfers at a rising edge with start_i high and busy_o low; the front end
// decodes it and places it in a four-entry operation queue, and busy_o rises only while
// that queue is full. The back end runs one operation at a time: a stored enqueue works
// two 64-bit seed multiplies as three 32x32 partial products each on one shared
// multiplier, a dequeue first reads the ring memory into a register, and a rejected or
// dropped enqueue, a recovery read or an unused action finishes in the execute state.
// Each command yields exactly one result, shown on res_o for a single cycle with
// res_valid_o high; the receiver cannot stall, so it must take every strobe. Ring
// contents need no clearing after reset.
module midi_event_queue_with_drop_flags_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  meq_pkg::cmd_t    cmd_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output meq_pkg::result_t res_o
);
  import meq_pkg::*;

  opq_status_t opq_status;
  op_t         push_op, pop_op;
  logic        push, pop;

  meq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .opq_status_i (opq_status),
    .busy_o       (busy_o),
    .push_o       (push),
    .op_o         (push_op)
  );

  meq_opq u_opq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (push_op),
    .pop_i    (pop),
    .op_o     (pop_op),
    .status_o (opq_status)
  );

  meq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opq_status_i (opq_status),
    .op_i         (pop_op),
    .pop_o        (pop),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule
